// ===== rtl/core/plmt_pkg.sv =====
// plmt_pkg: shared types, codes and sizes of the packet log merge table
// used by the interfaces, the table cell and the top level
package plmt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int IDXC_W      = (IDX_W > 8) ? IDX_W : 8;
   localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_LOG   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_APPENDED   = 3'd0,
      ST_MERGED     = 3'd1,
      ST_FULL       = 3'd2,
      ST_READ_OK    = 3'd3,
      ST_READ_EMPTY = 3'd4,
      ST_CLEARED    = 3'd5
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_BUSY = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        src_ip;
      logic [31:0]        dst_ip;
      logic [15:0]        sport;
      logic [15:0]        dport;
      logic [7:0]         protocol;
      logic [2:0]         hook;
      logic [7:0]         action;
      logic signed [31:0] reason;
      logic [31:0]        timestamp;
      logic [7:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         entry_index;
      logic [31:0]        entry_time;
      logic [31:0]        entry_src_ip;
      logic [31:0]        entry_dst_ip;
      logic [15:0]        entry_sport;
      logic [15:0]        entry_dport;
      logic [7:0]         entry_protocol;
      logic [2:0]         entry_hook;
      logic [7:0]         entry_action;
      logic signed [31:0] entry_reason;
      logic [31:0]        hit_count;
   } rsp_type;

   // request travelling down the chain with its result so far
   typedef struct packed {
      logic    valid;
      logic    done;
      req_type req;
      rsp_type res;
   } tok_type;

endpackage

// ===== rtl/core/plmt_if.sv =====
// plmt_req_if and plmt_rsp_if: valid/ready channels of the table
// depends on plmt_pkg for the payload types
interface plmt_req_if;
   logic              valid;
   logic              ready;
   plmt_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface plmt_rsp_if;
   logic              valid;
   logic              ready;
   plmt_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/packet_log_merge_table.sv =====
// Packet log merge table. Each request walks a row of TABLE_DEPTH cells,
// one cell per clock while the row is not held, and one request is in the
// row at a time, so a new request is taken only after the previous one has
// left the row. Each cell holds one slot; a log request merges into the
// slot with equal addresses, ports, reason, action and hook or is appended
// in the first free slot, a read returns one slot and a clear empties the
// row. A finished response waits in the output register; the row holds
// while it is not taken. Command 3 gives no response.
// depends on plmt_pkg, plmt_if and plmt_cell
module packet_log_merge_table (
   input logic        clock,
   input logic        reset,
   plmt_req_if.sink   req_if,
   plmt_rsp_if.source rsp_if
);
   import plmt_pkg::*;

   tok_type   tok [TABLE_DEPTH+1];
   tok_type   inject;
   tok_type   tail;
   logic      advance;
   logic      req_fire;
   logic      tail_emit;
   fsm_type   state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   assign tail      = tok[TABLE_DEPTH];
   assign tail_emit = tail.valid && (cmd_type'(tail.req.cmd) != CMD_NOP);
   assign advance   = !(tail_emit && rsp_valid_ff && !rsp_if.ready);
   assign req_fire  = req_if.valid && req_if.ready;

   // request enters with its default outcome
   always_comb begin
      inject       = '0;
      inject.valid = req_fire;
      inject.req   = req_if.data;
      case (cmd_type'(req_if.data.cmd))
         CMD_LOG:   inject.res.status = ST_FULL;
         CMD_CLEAR: inject.res.status = ST_CLEARED;
         CMD_READ: begin
            inject.res.status      = ST_READ_EMPTY;
            inject.res.entry_index = req_if.data.read_index;
         end
         default:   inject.res.status = ST_FULL;
      endcase
   end

   assign tok[0] = inject;

   // the row of slots
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      plmt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (IDX_W'(i)),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (req_fire) state_in = FSM_BUSY;
         FSM_BUSY: if (tail.valid && advance) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      case (state_ff)
         FSM_IDLE: req_if.ready = 1'b1;
         default:  req_if.ready = 1'b0;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      if (tail_emit && advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = tail.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_idle_empty_tail : assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_IDLE |-> !tail.valid)
      else $error("request left in the cell row while idle");
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == FSM_BUSY)
      else $error("accepted request did not start the row");
   a_rsp_from_tail : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tail_emit))
      else $error("response without a request at the end of the row");
`endif

endmodule

// ===== rtl/core/plmt_cell.sv =====
// plmt_cell: one table slot; checks the passing request against its entry
// depends on plmt_pkg
module plmt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [plmt_pkg::IDX_W-1:0] cell_idx,
   input  plmt_pkg::tok_type          tok_in,
   output plmt_pkg::tok_type          tok_out
);
   import plmt_pkg::*;

   logic               used_ff, used_in;
   logic [31:0]        time_ff, time_in;
   logic [31:0]        sip_ff, sip_in;
   logic [31:0]        dip_ff, dip_in;
   logic [15:0]        sport_ff, sport_in;
   logic [15:0]        dport_ff, dport_in;
   logic [7:0]         proto_ff, proto_in;
   logic [2:0]         hook_ff, hook_in;
   logic [7:0]         act_ff, act_in;
   logic signed [31:0] rsn_ff, rsn_in;
   logic [31:0]        hits_ff, hits_in;
   tok_type            tok_ff, tok_in_n;
   logic               key_hit;
   logic               idx_hit;
   logic [IDXC_W-1:0]  idx_wide;

   assign idx_wide = IDXC_W'(cell_idx);
   assign idx_hit  = (IDXC_W'(tok_in.req.read_index) == idx_wide);
   assign key_hit  = used_ff && (sip_ff == tok_in.req.src_ip)
                     && (dip_ff == tok_in.req.dst_ip)
                     && (sport_ff == tok_in.req.sport)
                     && (dport_ff == tok_in.req.dport)
                     && (rsn_ff == tok_in.req.reason)
                     && (act_ff == tok_in.req.action)
                     && (hook_ff == tok_in.req.hook);

   // merge, append, read or clear as the request passes
   always_comb begin
      used_in  = used_ff;
      time_in  = time_ff;
      sip_in   = sip_ff;
      dip_in   = dip_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      proto_in = proto_ff;
      hook_in  = hook_ff;
      act_in   = act_ff;
      rsn_in   = rsn_ff;
      hits_in  = hits_ff;
      tok_in_n = tok_in;
      if (tok_in.valid) begin
         case (cmd_type'(tok_in.req.cmd))
            CMD_LOG: begin
               if (!tok_in.done && key_hit) begin
                  time_in = tok_in.req.timestamp;
                  if (hits_ff != HITS_MAX) begin
                     hits_in = hits_ff + 32'd1;
                  end
                  tok_in_n.done       = 1'b1;
                  tok_in_n.res.status = ST_MERGED;
               end else if (!tok_in.done && !used_ff) begin
                  used_in  = 1'b1;
                  time_in  = tok_in.req.timestamp;
                  sip_in   = tok_in.req.src_ip;
                  dip_in   = tok_in.req.dst_ip;
                  sport_in = tok_in.req.sport;
                  dport_in = tok_in.req.dport;
                  proto_in = tok_in.req.protocol;
                  hook_in  = tok_in.req.hook;
                  act_in   = tok_in.req.action;
                  rsn_in   = tok_in.req.reason;
                  hits_in  = 32'd1;
                  tok_in_n.done       = 1'b1;
                  tok_in_n.res.status = ST_APPENDED;
               end
            end
            CMD_READ: begin
               if (!tok_in.done && idx_hit) begin
                  tok_in_n.done = 1'b1;
                  if (used_ff) begin
                     tok_in_n.res.status = ST_READ_OK;
                  end
               end
            end
            CMD_CLEAR: begin
               used_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      // fill in the slot contents after the update
      if (tok_in.valid && !tok_in.done && tok_in_n.done
          && tok_in_n.res.status != ST_READ_EMPTY) begin
         tok_in_n.res.entry_index    = idx_wide[7:0];
         tok_in_n.res.entry_time     = time_in;
         tok_in_n.res.entry_src_ip   = sip_in;
         tok_in_n.res.entry_dst_ip   = dip_in;
         tok_in_n.res.entry_sport    = sport_in;
         tok_in_n.res.entry_dport    = dport_in;
         tok_in_n.res.entry_protocol = proto_in;
         tok_in_n.res.entry_hook     = hook_in;
         tok_in_n.res.entry_action   = act_in;
         tok_in_n.res.entry_reason   = rsn_in;
         tok_in_n.res.hit_count      = hits_in;
      end
   end

   // slot contents
   always_ff @(posedge clock) begin
      if (advance) begin
         time_ff  <= time_in;
         sip_ff   <= sip_in;
         dip_ff   <= dip_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         proto_ff <= proto_in;
         hook_ff  <= hook_in;
         act_ff   <= act_in;
         rsn_ff   <= rsn_in;
         hits_ff  <= hits_in;
      end
   end

   // occupancy and hand-over to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         used_ff <= used_in;
         tok_ff  <= tok_in_n;
      end
   end

   assign tok_out = tok_ff;

endmodule
